FILE: src/fqdr_pkg.sv
package fqdr_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 5;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DATA_W-1:0] data_type;

   typedef enum logic [1:0] {
      KIND_PUSH    = 2'd0,
      KIND_POP     = 2'd1,
      KIND_DELETE  = 2'd2,
      KIND_REVERSE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_CAP,
      S_SHIFT,
      S_SEARCH,
      S_REV_RD,
      S_REV_WL,
      S_REV_WH,
      S_RESP
   } state_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  popped_value;
      logic [COUNT_W-1:0]        count;
   } result_type;

   // one write port, two read ports
   typedef struct packed {
      logic     we;
      idx_type  waddr;
      data_type wdata;
      logic     re_a;
      idx_type  raddr_a;
      logic     re_b;
      idx_type  raddr_b;
   } mem_req_type;

endpackage

FILE: src/fqdr_req_if.sv
interface fqdr_req_if;
   logic                             valid;
   logic                             ready;
   fqdr_pkg::kind_type               kind;
   logic signed [fqdr_pkg::DATA_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

FILE: src/fqdr_rsp_if.sv
interface fqdr_rsp_if;
   logic                               valid;
   logic                               ready;
   fqdr_pkg::status_type               status;
   logic signed [fqdr_pkg::DATA_W-1:0] popped_value;
   logic [fqdr_pkg::COUNT_W-1:0]       count;

   modport source (output valid, output status, output popped_value, output count,
                   input ready);
   modport sink   (input valid, input status, input popped_value, input count,
                   output ready);
endinterface

FILE: src/fqdr_ram.sv
module fqdr_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re_a,
   input  logic [ADDR_W-1:0] raddr_a,
   output logic [WIDTH-1:0]  rdata_a,
   input  logic              re_b,
   input  logic [ADDR_W-1:0] raddr_b,
   output logic [WIDTH-1:0]  rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re_a) begin
         rd_a_ff <= mem_ff[raddr_a];
      end
      if (re_b) begin
         rd_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rd_a_ff;
   assign rdata_b = rd_b_ff;

endmodule

FILE: src/fqdr_seq.sv
module fqdr_seq (
   input  logic                  clock,
   input  logic                  reset,
   fqdr_req_if.sink              req_ch,
   output fqdr_pkg::mem_req_type mem_req,
   input  fqdr_pkg::data_type    rd_a,
   input  fqdr_pkg::data_type    rd_b,
   output logic                  res_valid,
   output fqdr_pkg::result_type  res,
   input  logic                  res_ready
);
   import fqdr_pkg::*;

   state_type  state_ff,  state_in;
   cnt_type    count_ff,  count_in;
   data_type   value_ff,  value_in;
   cnt_type    src_ff,    src_in;
   idx_type    wr_ff,     wr_in;
   logic       pend_ff,   pend_in;
   idx_type    idx_ff,    idx_in;
   logic       more_ff,   more_in;
   idx_type    chk_ff,    chk_in;
   idx_type    lo_ff,     lo_in;
   idx_type    hi_ff,     hi_in;
   data_type   tmp_ff,    tmp_in;
   status_type status_ff, status_in;
   data_type   popped_ff, popped_in;

   logic accept;
   logic full;
   logic empty;
   logic single;
   logic src_live;
   logic hit;
   logic rev_more;

   assign accept   = req_ch.valid && req_ch.ready;
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign single   = (count_ff == CNT_W'(1));
   assign src_live = (src_ff < count_ff);
   assign hit      = pend_ff && (rd_a == value_ff);
   // another pair left to swap when lo + 1 < hi - 1
   assign rev_more = ({1'b0, lo_ff} + (IDX_W + 1)'(2)) < {1'b0, hi_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_ch.kind)
                  KIND_PUSH:    state_in = S_RESP;
                  KIND_POP:     state_in = empty ? S_RESP : S_POP_CAP;
                  KIND_DELETE:  state_in = empty ? S_RESP : S_SEARCH;
                  KIND_REVERSE: state_in = (empty || single) ? S_RESP : S_REV_RD;
                  default:      state_in = S_RESP;
               endcase
            end
         end
         S_POP_CAP: state_in = S_SHIFT;
         S_SHIFT: begin
            if (!src_live && !pend_ff) state_in = S_RESP;
         end
         S_SEARCH: begin
            priority if (hit)   state_in = S_SHIFT;
            else if (!more_ff)  state_in = S_RESP;
            else                state_in = S_SEARCH;
         end
         S_REV_RD: state_in = S_REV_WL;
         S_REV_WL: state_in = S_REV_WH;
         S_REV_WH: state_in = rev_more ? S_REV_WL : S_RESP;
         S_RESP: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory port and handshake outputs
   always_comb begin
      mem_req = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_ch.kind == KIND_PUSH && !full) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = count_ff[IDX_W-1:0];
               mem_req.wdata = req_ch.value;
            end
            if (accept && req_ch.kind == KIND_POP) begin
               mem_req.re_a    = 1'b1;
               mem_req.raddr_a = '0;
            end
         end
         S_SHIFT: begin
            mem_req.re_a    = src_live;
            mem_req.raddr_a = src_ff[IDX_W-1:0];
            mem_req.we      = pend_ff;
            mem_req.waddr   = wr_ff;
            mem_req.wdata   = rd_a;
         end
         S_SEARCH: begin
            mem_req.re_a    = more_ff;
            mem_req.raddr_a = idx_ff;
         end
         S_REV_RD: begin
            mem_req.re_a    = 1'b1;
            mem_req.raddr_a = lo_ff;
            mem_req.re_b    = 1'b1;
            mem_req.raddr_b = hi_ff;
         end
         S_REV_WL: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = lo_ff;
            mem_req.wdata = rd_b;
         end
         S_REV_WH: begin
            mem_req.we      = 1'b1;
            mem_req.waddr   = hi_ff;
            mem_req.wdata   = tmp_ff;
            mem_req.re_a    = rev_more;
            mem_req.raddr_a = lo_ff + IDX_W'(1);
            mem_req.re_b    = rev_more;
            mem_req.raddr_b = hi_ff - IDX_W'(1);
         end
         default: mem_req = '0;
      endcase
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign res_valid        = (state_ff == S_RESP);
   assign res.status       = status_ff;
   assign res.popped_value = popped_ff;
   assign res.count        = COUNT_W'(count_ff);

   // datapath next values
   always_comb begin
      count_in  = count_ff;
      value_in  = value_ff;
      src_in    = src_ff;
      wr_in     = wr_ff;
      pend_in   = pend_ff;
      idx_in    = idx_ff;
      more_in   = more_ff;
      chk_in    = chk_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      tmp_in    = tmp_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in  = req_ch.value;
               status_in = ST_OK;
               popped_in = '0;
               unique case (req_ch.kind)
                  KIND_PUSH: begin
                     if (full) status_in = ST_FULL;
                     else      count_in  = count_ff + CNT_W'(1);
                  end
                  KIND_POP: begin
                     if (empty) status_in = ST_EMPTY;
                     src_in  = CNT_W'(1);
                     wr_in   = '0;
                     pend_in = 1'b0;
                  end
                  KIND_DELETE: begin
                     if (empty) status_in = ST_EMPTY;
                     idx_in  = IDX_W'(count_ff - CNT_W'(1));
                     more_in = 1'b1;
                     pend_in = 1'b0;
                  end
                  KIND_REVERSE: begin
                     if (empty) status_in = ST_EMPTY;
                     lo_in = '0;
                     hi_in = IDX_W'(count_ff - CNT_W'(1));
                  end
                  default: status_in = ST_OK;
               endcase
            end
         end
         S_POP_CAP: popped_in = rd_a;
         S_SHIFT: begin
            pend_in = src_live;
            if (src_live) src_in = src_ff + CNT_W'(1);
            if (pend_ff)  wr_in  = wr_ff + IDX_W'(1);
            if (!src_live && !pend_ff) count_in = count_ff - CNT_W'(1);
         end
         S_SEARCH: begin
            priority if (hit) begin
               popped_in = value_ff;
               src_in    = CNT_W'(chk_ff) + CNT_W'(1);
               wr_in     = chk_ff;
               pend_in   = 1'b0;
            end else if (more_ff) begin
               chk_in  = idx_ff;
               pend_in = 1'b1;
               if (idx_ff == '0) more_in = 1'b0;
               else              idx_in  = idx_ff - IDX_W'(1);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         S_REV_WL: tmp_in = rd_a;
         S_REV_WH: begin
            if (rev_more) begin
               lo_in = lo_ff + IDX_W'(1);
               hi_in = hi_ff - IDX_W'(1);
            end
         end
         default: tmp_in = tmp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         more_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         more_ff  <= more_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      src_ff    <= src_in;
      wr_ff     <= wr_in;
      idx_ff    <= idx_in;
      chk_ff    <= chk_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      tmp_ff    <= tmp_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

endmodule

FILE: src/fqdr_out.sv
module fqdr_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  fqdr_pkg::result_type res,
   output logic                 res_ready,
   fqdr_rsp_if.source           rsp_ch
);
   import fqdr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff,  data_in;
   logic       load;

   assign res_ready = !valid_ff || rsp_ch.ready;
   assign load      = res_valid && res_ready;

   always_comb begin
      valid_in = load || (valid_ff && !rsp_ch.ready);
      data_in  = load ? res : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.status       = data_ff.status;
   assign rsp_ch.popped_value = data_ff.popped_value;
   assign rsp_ch.count        = data_ff.count;

endmodule

FILE: src/fifo_queue_with_delete_and_reverse_core.sv
// channel   dir  fields                                  transaction when
// req_ch    in   kind[1:0], value[31:0] signed           req_ch.valid & req_ch.ready
// rsp_ch    out  status[1:0], popped_value[31:0] signed, rsp_ch.valid & rsp_ch.ready
//                count[4:0]
//
// One request at a time; req_ch.ready is high only while the sequencer is idle.
// Push, any request on an empty queue and a single-entry reverse go straight to the response;
// pop shifts the remaining entries down, delete searches from the newest entry and shifts
// the later entries down on a hit, reverse swaps entries pairwise from both ends inward.
// Reset (synchronous) empties the queue and drops any held response; RAM is not cleared.
// A stalled rsp_ch holds its response while the next request is processed.
module fifo_queue_with_delete_and_reverse_core (
   input  logic       clock,
   input  logic       reset,
   fqdr_req_if.sink   req_ch,
   fqdr_rsp_if.source rsp_ch
);
   import fqdr_pkg::*;

   mem_req_type mem_req;
   data_type    rd_a;
   data_type    rd_b;
   logic        res_valid;
   logic        res_ready;
   result_type  res;

   // sequencer: count, pointers, result fields
   fqdr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .mem_req   (mem_req),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // entry storage, slot 0 oldest
   fqdr_ram #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_W)
   ) u_ram (
      .clock   (clock),
      .we      (mem_req.we),
      .waddr   (mem_req.waddr),
      .wdata   (mem_req.wdata),
      .re_a    (mem_req.re_a),
      .raddr_a (mem_req.raddr_a),
      .rdata_a (rd_a),
      .re_b    (mem_req.re_b),
      .raddr_b (mem_req.raddr_b),
      .rdata_b (rd_b)
   );

   // response register
   fqdr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: src/fqdr_checker.sv
module fqdr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input fqdr_pkg::status_type         rsp_status,
   input logic [fqdr_pkg::DATA_W-1:0]  rsp_popped_value,
   input logic [fqdr_pkg::COUNT_W-1:0] rsp_count
);
   import fqdr_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_count) <= DEPTH))
      else $error("count above depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_count == COUNT_W'(DEPTH)))
      else $error("full status with queue not full");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_count == '0 && rsp_popped_value == '0))
      else $error("empty status with nonzero count or value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_count)
                                     && $stable(rsp_popped_value)))
      else $error("stalled response changed");

endmodule

bind fifo_queue_with_delete_and_reverse_core fqdr_checker u_fqdr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_popped_value (rsp_ch.popped_value),
   .rsp_count        (rsp_ch.count)
);
